// ----- design/rtte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_pkg: shared constants and types for the RTT / retransmit timeout block
// Widths of the fixed-point state, the queue depth and the reciprocal
// constants used to split the timeout into seconds and microseconds.
// ----------------------------------------------------------------------------
package rtte_pkg;

  // Input sample and fixed-point state
  localparam int SAMPLE_W  = 26;
  localparam int FRAC_BITS = 8;
  localparam int STATE_W   = SAMPLE_W + FRAC_BITS;
  // timeout = srtt + 4 * dev stays below 2^(STATE_W+3), truncated to whole us
  localparam int TMO_W     = STATE_W + 3;
  localparam int TOTAL_W   = TMO_W - FRAC_BITS;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int SEC_W       = 9;
  localparam int MICROS_W    = 20;
  localparam int OUT_TDATA_W = 64;

  // Input queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Division by 1e6 = 2^6 * 15625: shift, then multiply by reciprocal
  localparam int US_PER_SEC  = 1000000;
  localparam int DIV_SHIFT   = 6;
  localparam int T6_W        = TOTAL_W - DIV_SHIFT;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd15625);
  localparam int PROD_W      = T6_W + RECIP_W;
  localparam int REM_W       = MICROS_W + 1;

  // Smoothed state handed from the update pipeline to the output side
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] srtt;
    logic [STATE_W-1:0] dev;
  } smooth_out_t;

endpackage

// ----- design/rtte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_front: input request queue
// Accepts samples from the input stream into a short queue so that the
// input side keeps taking requests while the update pipeline stalls.
// ----------------------------------------------------------------------------
module rtte_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rtte_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            adv,
  output logic                            q_valid,
  output logic [rtte_pkg::SAMPLE_W-1:0]   q_sample
);
  import rtte_pkg::*;

  logic [SAMPLE_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0]   head_r, head_nxt;
  logic [QPTR_W-1:0]   tail_r, tail_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_sample  = mem_r[head_r];

  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && adv;

  // Pointer and fill count
  always_comb begin
    head_nxt = pop  ? head_r + 1'b1 : head_r;
    tail_nxt = push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= in_sample;
    end
  end

  // Fill count stays within the queue
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  // Count tracks a push without a pop
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

// ----- design/rtte_smooth.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_smooth: smoothed RTT and deviation update pipeline
// Stage 1 updates the smoothed RTT, stage 2 forms |sample - srtt|, stage 3
// updates the smoothed deviation. All stages move on a common advance.
// ----------------------------------------------------------------------------
module rtte_smooth (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           q_valid,
  input  logic [rtte_pkg::SAMPLE_W-1:0]  q_sample,
  output rtte_pkg::smooth_out_t          sm_out
);
  import rtte_pkg::*;

  logic [STATE_W-1:0] srtt_r, srtt_nxt;
  logic [STATE_W-1:0] dev_r, dev_nxt;
  logic [STATE_W-1:0] scaled;
  logic [STATE_W+2:0] rsum;
  logic [STATE_W+1:0] dsum;
  logic [STATE_W-1:0] diff;

  logic               s1_valid_r;
  logic [STATE_W-1:0] s1_samp_r;
  logic               s2_valid_r;
  logic [STATE_W-1:0] s2_diff_r;
  logic [STATE_W-1:0] s2_srtt_r;
  logic               s3_valid_r;
  logic [STATE_W-1:0] s3_srtt_r;

  // Stage 1: srtt = (7 * srtt + S) >> 3
  assign scaled   = {q_sample, {FRAC_BITS{1'b0}}};
  assign rsum     = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, scaled};
  assign srtt_nxt = rsum[STATE_W+2:3];

  // Stage 2: absolute distance of the sample from the new srtt
  assign diff = (s1_samp_r >= srtt_r) ? (s1_samp_r - srtt_r) : (srtt_r - s1_samp_r);

  // Stage 3: dev = (3 * dev + diff) >> 2
  assign dsum    = {1'b0, dev_r, 1'b0} + {2'b00, dev_r} + {2'b00, s2_diff_r};
  assign dev_nxt = dsum[STATE_W+1:2];

  // Control state and averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r     <= '0;
      dev_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (q_valid) begin
        srtt_r <= srtt_nxt;
      end
      if (s2_valid_r) begin
        dev_r <= dev_nxt;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_samp_r <= scaled;
      s2_diff_r <= diff;
      s2_srtt_r <= srtt_r;
      s3_srtt_r <= s2_srtt_r;
    end
  end

  assign sm_out.valid = s3_valid_r;
  assign sm_out.srtt  = s3_srtt_r;
  assign sm_out.dev   = dev_r;

endmodule

// ----- design/rtte_divide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_divide: timeout sum and seconds / microseconds split
// Forms srtt + 4 * dev in whole microseconds, divides by 1e6 through a
// reciprocal multiply with one correction step and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module rtte_divide (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rtte_pkg::smooth_out_t              sm_out,
  output logic                               adv,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rtte_pkg::SEC_W-1:0]         out_sec,
  output logic [rtte_pkg::MICROS_W-1:0]      out_micros,
  output logic [rtte_pkg::TOTAL_W-1:0]       out_total
);
  import rtte_pkg::*;

  logic [TMO_W-1:0]    tmo;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  qmul;
  logic [TOTAL_W-1:0]  rem_full;
  logic                over;

  logic                a_valid_r;
  logic [TOTAL_W-1:0]  a_total_r;
  logic                b_valid_r;
  logic [TOTAL_W-1:0]  b_total_r;
  logic [PROD_W-1:0]   b_prod_r;
  logic                c_valid_r;
  logic [TOTAL_W-1:0]  c_total_r;
  logic [SEC_W-1:0]    c_q_r;
  logic [REM_W-1:0]    c_rem_r;
  logic                o_valid_r;
  logic [SEC_W-1:0]    o_sec_r;
  logic [MICROS_W-1:0] o_micros_r;
  logic [TOTAL_W-1:0]  o_total_r;
  logic [SEC_W-1:0]    qest;

  assign adv = !o_valid_r || out_tready;

  // Stage A: timeout in whole microseconds
  assign tmo   = {3'b000, sm_out.srtt} + {1'b0, sm_out.dev, 2'b00};
  assign total = tmo[TMO_W-1:FRAC_BITS];

  // Stage C: quotient estimate and raw remainder
  assign qest     = b_prod_r[RECIP_SHIFT +: SEC_W];
  assign qmul     = TOTAL_W'(qest * TOTAL_W'(US_PER_SEC));
  assign rem_full = b_total_r - qmul;

  // Output: estimate is low by at most one
  assign over = (c_rem_r >= REM_W'(US_PER_SEC));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= sm_out.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      o_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_total_r  <= total;
      b_total_r  <= a_total_r;
      b_prod_r   <= PROD_W'(a_total_r[TOTAL_W-1:DIV_SHIFT]) * PROD_W'(RECIP);
      c_total_r  <= b_total_r;
      c_q_r      <= qest;
      c_rem_r    <= rem_full[REM_W-1:0];
      o_total_r  <= c_total_r;
      o_sec_r    <= over ? c_q_r + 1'b1 : c_q_r;
      o_micros_r <= over ? MICROS_W'(c_rem_r - REM_W'(US_PER_SEC))
                         : c_rem_r[MICROS_W-1:0];
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_sec    = o_sec_r;
  assign out_micros = o_micros_r;
  assign out_total  = o_total_r;

  // Remainder below one second
  a_micros_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_micros_r < MICROS_W'(US_PER_SEC)))
    else $error("microsecond remainder out of range");

  // Seconds and remainder recombine to the total
  a_split_exact: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> ((TOTAL_W'(o_sec_r) * TOTAL_W'(US_PER_SEC) + TOTAL_W'(o_micros_r))
                   == o_total_r))
    else $error("seconds split does not match total");

endmodule

// ----- design/rtt_retransmit_timeout_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_retransmit_timeout_estimator: Jacobson/Karels RTT estimator
// Top level: input queue, smoothing pipeline and timeout split.
// ----------------------------------------------------------------------------
// One RTT sample request in, one retransmit timeout out, at one item per
// clock cycle while the output does not stall. A sample passes a 4-entry
// input queue, three update stages (srtt, |sample - srtt|, deviation) and
// four output stages (timeout sum, reciprocal multiply, remainder,
// correction into the output register). The averages reset to zero, so the
// first timeouts are small. Back-pressure on the output stalls the
// pipeline; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module rtt_retransmit_timeout_estimator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [25:0] sample_rtt_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [8:0] timeout_seconds, [28:9] timeout_micros,
                                  // [57:29] timeout_total_us
);
  import rtte_pkg::*;

  logic                adv;
  logic                q_valid;
  logic [SAMPLE_W-1:0] q_sample;
  smooth_out_t         sm_out;
  logic [SEC_W-1:0]    out_sec;
  logic [MICROS_W-1:0] out_micros;
  logic [TOTAL_W-1:0]  out_total;

  rtte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .adv       (adv),
    .q_valid   (q_valid),
    .q_sample  (q_sample)
  );

  rtte_smooth u_smooth (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .q_valid  (q_valid),
    .q_sample (q_sample),
    .sm_out   (sm_out)
  );

  rtte_divide u_divide (
    .clk        (clk),
    .rst_n      (rst_n),
    .sm_out     (sm_out),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sec    (out_sec),
    .out_micros (out_micros),
    .out_total  (out_total)
  );

  // Pack result fields, lowest field first, zero fill to 64 bits
  assign out_tdata = {{(OUT_TDATA_W - SEC_W - MICROS_W - TOTAL_W){1'b0}},
                      out_total, out_micros, out_sec};

endmodule
